// ----- src/olte_pkg.sv -----
// ----------------------------------------------------------------------------
// olte_pkg
// shared types, codes and default sizes of the ordered list table engine
// ----------------------------------------------------------------------------
package olte_pkg;

  // default sizes
  localparam int CapacityDef  = 128;
  localparam int DataWidthDef = 32;

  // fixed port field widths
  localparam int KindW  = 3;
  localparam int PosW   = 8;
  localparam int ValW   = 32;
  localparam int StW    = 2;
  localparam int FoundW = 7;
  localparam int CountW = 8;

  // request kinds
  typedef enum logic [KindW-1:0] {
    K_INSERT = 3'd0,
    K_REMOVE = 3'd1,
    K_READ   = 3'd2,
    K_FIND   = 3'd3,
    K_APPEND = 3'd4
  } kind_e;

  // result status codes
  typedef enum logic [StW-1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  // memory read address select
  typedef enum logic [2:0] {
    RA_PTR     = 3'd0,
    RA_POS     = 3'd1,
    RA_LAST    = 3'd2,
    RA_NEXT    = 3'd3,
    RA_PREV    = 3'd4,
    RA_POSNEXT = 3'd5,
    RA_ZERO    = 3'd6
  } addr_sel_e;

  // memory write address and data select
  typedef enum logic [1:0] {
    WR_POS = 2'd0,
    WR_UP  = 2'd1,
    WR_DN  = 2'd2
  } wr_sel_e;

  // controller to datapath commands
  typedef struct packed {
    logic      in_load;
    addr_sel_e rd_sel;
    logic      wr_en;
    wr_sel_e   wr_sel;
    logic      cnt_inc;
    logic      cnt_dec;
    logic      st_set;
    status_e   st;
    logic      data_load;
    logic      found_load;
    logic      res_load;
  } ctl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [KindW-1:0] kind;
    logic             pos_gt_cnt;
    logic             pos_ge_cnt;
    logic             pos_eq_cnt;
    logic             pos_last;
    logic             full;
    logic             cnt_zero;
    logic             ptr_at_pos;
    logic             ptr_at_last;
    logic             match;
    logic             out_busy;
  } dp_stat_t;

endpackage

// ----- src/ordered_list_table_engine.sv -----
// ----------------------------------------------------------------------------
// ordered_list_table_engine
// positional list store with insert, remove, read, find and append requests
// ----------------------------------------------------------------------------
// usage
//   request word on the in channel (kind_i, position_i, value_i), one result
//   word per request on the out channel (status, read data, found index,
//   count after the request, empty flag)
//   one request is worked at a time; in_ready_o is high only while idle
//   insert at position p moves entries p to count - 1 up one place, remove
//   at p moves entries p + 1 to count - 1 down one place, and find compares
//   entries from index 0 up to the first match or the last entry; read,
//   tail insert/append and errors need no walk; the entry memory moves or
//   compares one entry per cycle on its single port pair
//   the result sits in an output register; a new request is taken while it
//   waits, and a finished request holds in its last step until out_ready_i
//   frees the output register
//   reset empties the list at once (count cleared); stored words are not
//   cleared, since only entries below the count are ever read
// ----------------------------------------------------------------------------
module ordered_list_table_engine #(
  parameter int CAPACITY   = olte_pkg::CapacityDef,
  parameter int DATA_WIDTH = olte_pkg::DataWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [olte_pkg::KindW-1:0]    kind_i,
  input  logic [olte_pkg::PosW-1:0]     position_i,
  input  logic [olte_pkg::ValW-1:0]     value_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [olte_pkg::StW-1:0]      status_o,
  output logic [olte_pkg::ValW-1:0]     read_data_o,
  output logic [olte_pkg::FoundW-1:0]   found_index_o,
  output logic [olte_pkg::CountW-1:0]   count_o,
  output logic                          empty_res_o
);

  // command and status between sequencer and datapath
  olte_pkg::ctl_cmd_t cmd;
  olte_pkg::dp_stat_t stat;

  // sequencer: decode, shift walks, search walk, result hand-off
  olte_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // datapath: entry memory, count, pointer and result register
  olte_dpath #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .kind_i        (kind_i),
    .position_i    (position_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .read_data_o   (read_data_o),
    .found_index_o (found_index_o),
    .count_o       (count_o),
    .empty_res_o   (empty_res_o)
  );

  // one request at a time: busy right after taking a word
  a_busy_after_accept: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o
  ) else $error("request taken while previous one still in work");

  // an empty list reports a zero count
  a_empty_count: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && empty_res_o) |-> (count_o == '0)
  ) else $error("empty flag with nonzero count");

  // a nonzero found index only comes with a successful request
  a_found_ok: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (found_index_o != '0)) |-> (status_o == olte_pkg::ST_OK)
  ) else $error("found index set on a failed request");

  // read data only comes with a successful request
  a_data_ok: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (read_data_o != '0)) |-> (status_o == olte_pkg::ST_OK)
  ) else $error("read data set on a failed request");

endmodule

// ----- src/olte_ctrl.sv -----
// ----------------------------------------------------------------------------
// olte_ctrl
// request sequencer: decodes a request and steps the shift, search and read
// ----------------------------------------------------------------------------
module olte_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  olte_pkg::dp_stat_t  stat_i,
  output olte_pkg::ctl_cmd_t  cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DECODE = 8'b0000_0010,
    S_UP     = 8'b0000_0100,
    S_PUT    = 8'b0000_1000,
    S_DN     = 8'b0001_0000,
    S_RDW    = 8'b0010_0000,
    S_FIND   = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.rd_sel  = olte_pkg::RA_PTR;
    cmd_o.wr_sel  = olte_pkg::WR_POS;
    cmd_o.st      = olte_pkg::ST_OK;
    case (state_q)
      S_IDLE: begin
        cmd_o.in_load = in_valid_i;
        if (in_valid_i) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_DONE;
        case (stat_i.kind)
          olte_pkg::K_INSERT, olte_pkg::K_APPEND: begin
            if (stat_i.pos_gt_cnt) begin
              cmd_o.st_set = 1'b1;
              cmd_o.st     = olte_pkg::ST_RANGE;
            end else if (stat_i.full) begin
              cmd_o.st_set = 1'b1;
              cmd_o.st     = olte_pkg::ST_FULL;
            end else if (stat_i.pos_eq_cnt) begin
              state_d = S_PUT;
            end else begin
              cmd_o.rd_sel = olte_pkg::RA_LAST;
              state_d      = S_UP;
            end
          end
          olte_pkg::K_REMOVE: begin
            if (stat_i.pos_ge_cnt) begin
              cmd_o.st_set = 1'b1;
              cmd_o.st     = olte_pkg::ST_RANGE;
            end else if (stat_i.pos_last) begin
              cmd_o.cnt_dec = 1'b1;
            end else begin
              cmd_o.rd_sel = olte_pkg::RA_POSNEXT;
              state_d      = S_DN;
            end
          end
          olte_pkg::K_READ: begin
            if (stat_i.pos_ge_cnt) begin
              cmd_o.st_set = 1'b1;
              cmd_o.st     = olte_pkg::ST_RANGE;
            end else begin
              cmd_o.rd_sel = olte_pkg::RA_POS;
              state_d      = S_RDW;
            end
          end
          olte_pkg::K_FIND: begin
            if (stat_i.cnt_zero) begin
              cmd_o.st_set = 1'b1;
              cmd_o.st     = olte_pkg::ST_NOTFOUND;
            end else begin
              cmd_o.rd_sel = olte_pkg::RA_ZERO;
              state_d      = S_FIND;
            end
          end
          default: begin
            cmd_o.st_set = 1'b1;
            cmd_o.st     = olte_pkg::ST_RANGE;
          end
        endcase
      end
      S_UP: begin
        // move entry one place up, walking down toward the target
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = olte_pkg::WR_UP;
        if (stat_i.ptr_at_pos) begin
          state_d = S_PUT;
        end else begin
          cmd_o.rd_sel = olte_pkg::RA_PREV;
        end
      end
      S_PUT: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_sel  = olte_pkg::WR_POS;
        cmd_o.cnt_inc = 1'b1;
        state_d       = S_DONE;
      end
      S_DN: begin
        // move entry one place down, walking up toward the tail
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = olte_pkg::WR_DN;
        if (stat_i.ptr_at_last) begin
          cmd_o.cnt_dec = 1'b1;
          state_d       = S_DONE;
        end else begin
          cmd_o.rd_sel = olte_pkg::RA_NEXT;
        end
      end
      S_RDW: begin
        cmd_o.data_load = 1'b1;
        state_d         = S_DONE;
      end
      S_FIND: begin
        if (stat_i.match) begin
          cmd_o.found_load = 1'b1;
          state_d          = S_DONE;
        end else if (stat_i.ptr_at_last) begin
          cmd_o.st_set = 1'b1;
          cmd_o.st     = olte_pkg::ST_NOTFOUND;
          state_d      = S_DONE;
        end else begin
          cmd_o.rd_sel = olte_pkg::RA_NEXT;
        end
      end
      S_DONE: begin
        if (!stat_i.out_busy) begin
          cmd_o.res_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- src/olte_dpath.sv -----
// ----------------------------------------------------------------------------
// olte_dpath
// entry memory, count, walk pointer, request and result registers
// ----------------------------------------------------------------------------
module olte_dpath #(
  parameter int CAPACITY   = olte_pkg::CapacityDef,
  parameter int DATA_WIDTH = olte_pkg::DataWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  olte_pkg::ctl_cmd_t            cmd_i,
  output olte_pkg::dp_stat_t            stat_o,
  input  logic [olte_pkg::KindW-1:0]    kind_i,
  input  logic [olte_pkg::PosW-1:0]     position_i,
  input  logic [olte_pkg::ValW-1:0]     value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [olte_pkg::StW-1:0]      status_o,
  output logic [olte_pkg::ValW-1:0]     read_data_o,
  output logic [olte_pkg::FoundW-1:0]   found_index_o,
  output logic [olte_pkg::CountW-1:0]   count_o,
  output logic                          empty_res_o
);

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CmpW = (CW > olte_pkg::PosW) ? CW : olte_pkg::PosW;

  logic [DATA_WIDTH-1:0] mem_q [CAPACITY];
  logic [DATA_WIDTH-1:0] rd_q;
  logic [AW-1:0]         ptr_q;
  logic [AW-1:0]         rd_addr;
  logic [AW-1:0]         wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  logic [AW-1:0]         last_a;
  logic [AW-1:0]         pos_a;

  logic [CW-1:0]                count_q;
  logic [CmpW-1:0]              pos_q;
  logic [CmpW-1:0]              cnt_x;
  logic [DATA_WIDTH-1:0]        word_q;
  logic [63:0]                  val_x;
  logic [olte_pkg::KindW-1:0]   kind_q;
  olte_pkg::status_e            st_q;
  logic [DATA_WIDTH-1:0]        data_q;
  logic [AW-1:0]                found_q;

  logic                         out_valid_q;
  logic [olte_pkg::StW-1:0]     res_st_q;
  logic [DATA_WIDTH-1:0]        res_data_q;
  logic [AW-1:0]                res_found_q;
  logic [CW-1:0]                res_cnt_q;
  logic [63:0]                  res_data_x;
  logic [15:0]                  res_found_x;
  logic [15:0]                  res_cnt_x;

  assign val_x  = 64'(value_i);
  assign cnt_x  = CmpW'(count_q);
  assign last_a = AW'(count_q - 1'b1);
  assign pos_a  = pos_q[AW-1:0];

  always_comb begin
    case (cmd_i.rd_sel)
      olte_pkg::RA_POS:     rd_addr = pos_a;
      olte_pkg::RA_LAST:    rd_addr = last_a;
      olte_pkg::RA_NEXT:    rd_addr = AW'(ptr_q + 1'b1);
      olte_pkg::RA_PREV:    rd_addr = AW'(ptr_q - 1'b1);
      olte_pkg::RA_POSNEXT: rd_addr = AW'(pos_a + 1'b1);
      olte_pkg::RA_ZERO:    rd_addr = '0;
      default:              rd_addr = ptr_q;
    endcase
  end

  always_comb begin
    case (cmd_i.wr_sel)
      olte_pkg::WR_UP: begin
        wr_addr = AW'(ptr_q + 1'b1);
        wr_data = rd_q;
      end
      olte_pkg::WR_DN: begin
        wr_addr = AW'(ptr_q - 1'b1);
        wr_data = rd_q;
      end
      default: begin
        wr_addr = pos_a;
        wr_data = word_q;
      end
    endcase
  end

  // entry memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_q  <= mem_q[rd_addr];
    ptr_q <= rd_addr;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      kind_q  <= kind_i;
      word_q  <= val_x[DATA_WIDTH-1:0];
      pos_q   <= (kind_i == olte_pkg::K_APPEND) ? cnt_x : CmpW'(position_i);
      st_q    <= olte_pkg::ST_OK;
      data_q  <= '0;
      found_q <= '0;
    end else begin
      if (cmd_i.st_set) begin
        st_q <= cmd_i.st;
      end
      if (cmd_i.data_load) begin
        data_q <= rd_q;
      end
      if (cmd_i.found_load) begin
        found_q <= ptr_q;
      end
    end
    if (cmd_i.res_load) begin
      res_st_q    <= st_q;
      res_data_q  <= data_q;
      res_found_q <= found_q;
      res_cnt_q   <= count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.cnt_inc) begin
        count_q <= CW'(count_q + 1'b1);
      end else if (cmd_i.cnt_dec) begin
        count_q <= CW'(count_q - 1'b1);
      end
      if (cmd_i.res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    stat_o             = '0;
    stat_o.kind        = kind_q;
    stat_o.pos_gt_cnt  = (pos_q > cnt_x);
    stat_o.pos_ge_cnt  = (pos_q >= cnt_x);
    stat_o.pos_eq_cnt  = (pos_q == cnt_x);
    stat_o.pos_last    = (CmpW'(pos_q + 1'b1) == cnt_x);
    stat_o.full        = (count_q == CW'(CAPACITY));
    stat_o.cnt_zero    = (count_q == '0);
    stat_o.ptr_at_pos  = (ptr_q == pos_a);
    stat_o.ptr_at_last = (ptr_q == last_a);
    stat_o.match       = (rd_q == word_q);
    stat_o.out_busy    = out_valid_q & ~out_ready_i;
  end

  assign res_data_x  = 64'(res_data_q);
  assign res_found_x = 16'(res_found_q);
  assign res_cnt_x   = 16'(res_cnt_q);

  assign out_valid_o   = out_valid_q;
  assign status_o      = res_st_q;
  assign read_data_o   = res_data_x[olte_pkg::ValW-1:0];
  assign found_index_o = res_found_x[olte_pkg::FoundW-1:0];
  assign count_o       = res_cnt_x[olte_pkg::CountW-1:0];
  assign empty_res_o   = (res_cnt_q == '0);

endmodule
